// File: rtl/dnsx_pkg.sv
// Package for the DNS answer address extractor.
// Holds the transfer payload types, the parse phase encoding, the parser constants and the queue sizes.
// No dependencies; every other file in rtl imports it.
`default_nettype none

package dnsx_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
  } packet_in_t;

  typedef enum logic [1:0] {
    KIND_ADDRESS   = 2'd0,
    KIND_OK        = 2'd1,
    KIND_REJECTED  = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  address_byte;
    logic        is_ipv6;
    logic        address_end;
    logic [3:0]  response_code;
    logic [17:0] address_count;
    logic        run_end;
  } result_t;

  // Results produced by one accepted byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QPTR   = 4'd2,
    PH_QFIXED = 4'd3,
    PH_RNAME  = 4'd4,
    PH_RPTR   = 4'd5,
    PH_RFIXED = 4'd6,
    PH_RDATA  = 4'd7,
    PH_DONE   = 4'd8,
    PH_REJECT = 4'd9
  } phase_t;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [7:0]  PTR_MARK  = 8'd192;

  localparam logic [3:0] RCODE_INDEX  = 4'd3;
  localparam logic [3:0] COUNT_FIRST  = 4'd6;
  localparam logic [3:0] HEADER_LAST  = 4'd11;
  localparam logic [3:0] QFIXED_LAST  = 4'd3;
  localparam logic [3:0] RTYPE_HI     = 4'd0;
  localparam logic [3:0] RTYPE_LO     = 4'd1;
  localparam logic [3:0] RDLEN_HI     = 4'd8;
  localparam logic [3:0] RDLEN_LO     = 4'd9;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

endpackage

`default_nettype wire

// File: rtl/dns_answer_address_extractor_top.sv
// Top level of the DNS answer address extractor.
// Joins the byte parser and the result queue; depends on dnsx_pkg, dnsx_parser
// and dnsx_result_fifo.
//
//   channel   direction  payload       handshake
//   byte      in         packet_in_t   byte_valid / byte_stall
//   result    out        result_t      result_valid / result_stall
//
// One message byte is taken per cycle while byte_stall is low; its results enter the queue
// at that edge and can be taken from the next cycle on, one per cycle unless stalled.
// An address byte that is also the final byte gives two results, delivered in turn.
// byte_stall rises while the four-entry result queue has fewer than two free slots.
// Reset is synchronous and clears the parser and the queue; the block then waits for a header.
`default_nettype none

module dns_answer_address_extractor_top (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  byte_valid,
  output logic                 byte_stall,
  input  dnsx_pkg::packet_in_t byte_item,
  output logic                 result_valid,
  input  wire                  result_stall,
  output dnsx_pkg::result_t    result_item
);
  import dnsx_pkg::*;

  push_t push;
  logic  room;
  logic  step;

  assign byte_stall = !room;
  assign step       = byte_valid && room;

  dnsx_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (byte_item),
    .push (push)
  );

  dnsx_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (result_valid),
    .stall (result_stall),
    .data  (result_item)
  );

endmodule

`default_nettype wire

// File: rtl/dnsx_parser.sv
// Byte-level DNS response parser: phase and counter registers plus next-state logic.
// Produces up to two results per accepted byte as one push bundle.
// Depends on dnsx_pkg.
`default_nettype none

module dnsx_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 step,
  input  dnsx_pkg::packet_in_t item,
  output dnsx_pkg::push_t     push
);
  import dnsx_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  header_index, header_index_next;
  logic [17:0] records_left, records_left_next;
  logic [15:0] skip_countdown, skip_countdown_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] rdata_length, rdata_length_next;
  logic [3:0]  saved_rcode, saved_rcode_next;
  logic [17:0] addresses_found, addresses_found_next;

  logic [7:0]  b;
  logic        emit_addr;
  logic        finish;
  logic        is_addr_type;
  logic [15:0] rdata_left;
  logic [15:0] type_sel;
  logic [15:0] len_sel;
  logic [17:0] left_dec;
  result_t     addr_res;
  result_t     done_res;

  assign b            = item.packet_byte;
  assign is_addr_type = (record_type == TYPE_A) || (record_type == TYPE_AAAA);
  assign rdata_left   = skip_countdown - 16'd1;
  assign left_dec     = records_left - 18'd1;

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    records_left_next    = records_left;
    skip_countdown_next  = skip_countdown;
    record_type_next     = record_type;
    rdata_length_next    = rdata_length;
    saved_rcode_next     = saved_rcode;
    addresses_found_next = addresses_found;
    emit_addr            = 1'b0;
    finish               = 1'b0;
    type_sel             = record_type;
    len_sel              = rdata_length;
    if (step) begin
      unique case (phase)
        PH_HEADER: begin
          if (header_index == RCODE_INDEX) begin
            saved_rcode_next = b[3:0];
          end
          if (header_index >= COUNT_FIRST) begin
            if (!header_index[0]) begin
              skip_countdown_next = {8'h00, b};
            end else begin
              records_left_next = records_left + {2'b00, skip_countdown[7:0], b};
            end
          end
          if ((header_index == RCODE_INDEX) && (b[3:0] != 4'h0)) begin
            phase_next = PH_REJECT;
          end else if (header_index >= HEADER_LAST) begin
            phase_next          = PH_QNAME;
            header_index_next   = 4'd0;
            skip_countdown_next = 16'd0;
          end else begin
            header_index_next = header_index + 4'd1;
          end
        end
        PH_QNAME, PH_RNAME: begin
          if (skip_countdown != 16'd0) begin
            skip_countdown_next = rdata_left;
          end else if (b == 8'd0) begin
            phase_next        = (phase == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
            header_index_next = 4'd0;
          end else if (b >= PTR_MARK) begin
            phase_next = (phase == PH_QNAME) ? PH_QPTR : PH_RPTR;
          end else begin
            skip_countdown_next = {8'h00, b};
          end
        end
        PH_QPTR: begin
          phase_next        = PH_QFIXED;
          header_index_next = 4'd0;
        end
        PH_RPTR: begin
          phase_next        = PH_RFIXED;
          header_index_next = 4'd0;
        end
        PH_QFIXED: begin
          if (header_index >= QFIXED_LAST) begin
            phase_next          = (records_left == 18'd0) ? PH_DONE : PH_RNAME;
            header_index_next   = 4'd0;
            skip_countdown_next = 16'd0;
          end else begin
            header_index_next = header_index + 4'd1;
          end
        end
        PH_RFIXED: begin
          if (header_index == RTYPE_HI) begin
            type_sel = {b, 8'h00};
          end else if (header_index == RTYPE_LO) begin
            type_sel = {record_type[15:8], b};
          end else if (header_index == RDLEN_HI) begin
            len_sel = {b, 8'h00};
          end else if (header_index == RDLEN_LO) begin
            len_sel = {rdata_length[15:8], b};
          end
          record_type_next  = type_sel;
          rdata_length_next = len_sel;
          if (header_index >= RDLEN_LO) begin
            header_index_next = 4'd0;
            if ((type_sel == TYPE_A) || (type_sel == TYPE_AAAA)) begin
              addresses_found_next = addresses_found + 18'd1;
            end
            if (len_sel == 16'd0) begin
              finish = 1'b1;
            end else begin
              skip_countdown_next = len_sel;
              phase_next          = PH_RDATA;
            end
          end else begin
            header_index_next = header_index + 4'd1;
          end
        end
        PH_RDATA: begin
          skip_countdown_next = rdata_left;
          emit_addr           = is_addr_type;
          if (rdata_left == 16'd0) begin
            finish = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (finish) begin
        records_left_next   = left_dec;
        phase_next          = (left_dec == 18'd0) ? PH_DONE : PH_RNAME;
        skip_countdown_next = 16'd0;
      end
    end
  end

  always_comb begin
    addr_res               = '0;
    addr_res.result_kind   = KIND_ADDRESS;
    addr_res.address_byte  = b;
    addr_res.is_ipv6       = (record_type == TYPE_AAAA);
    addr_res.address_end   = (rdata_left == 16'd0);
    addr_res.run_end       = !item.end_of_packet;

    done_res               = '0;
    priority if (phase_next == PH_REJECT) begin
      done_res.result_kind = KIND_REJECTED;
    end else if (phase_next == PH_DONE) begin
      done_res.result_kind = KIND_OK;
    end else begin
      done_res.result_kind = KIND_TRUNCATED;
    end
    done_res.response_code = saved_rcode_next;
    done_res.address_count = addresses_found_next;
    done_res.run_end       = 1'b1;

    push = '0;
    if (step) begin
      if (emit_addr) begin
        push.first = addr_res;
        if (item.end_of_packet) begin
          push.second = done_res;
          push.count  = 2'd2;
        end else begin
          push.count = 2'd1;
        end
      end else if (item.end_of_packet) begin
        push.first = done_res;
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_packet)) begin
      phase           <= PH_HEADER;
      header_index    <= 4'd0;
      records_left    <= 18'd0;
      skip_countdown  <= 16'd0;
      record_type     <= 16'd0;
      rdata_length    <= 16'd0;
      saved_rcode     <= 4'd0;
      addresses_found <= 18'd0;
    end else begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      records_left    <= records_left_next;
      skip_countdown  <= skip_countdown_next;
      record_type     <= record_type_next;
      rdata_length    <= rdata_length_next;
      saved_rcode     <= saved_rcode_next;
      addresses_found <= addresses_found_next;
    end
  end

  // The final byte of a message always yields a completion result marked as the last.
  a_eop_completes: assert property (@(posedge clk) disable iff (rst)
    (step && item.end_of_packet) |->
      (push.count != 2'd0) && (push.count == 2'd1 ? push.first.run_end : push.second.run_end))
    else $error("final byte did not end with a completion result");

  // After the final byte the parser is back at the start of a header.
  a_eop_resets: assert property (@(posedge clk) disable iff (rst)
    (step && item.end_of_packet) |=> (phase == PH_HEADER) && (header_index == 4'd0)
      && (addresses_found == 18'd0))
    else $error("parser state not cleared after the final byte");

  // A rejected message stays rejected until its final byte.
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_REJECT) && !(step && item.end_of_packet) |=> (phase == PH_REJECT))
    else $error("left the rejected phase before the final byte");

endmodule

`default_nettype wire

// File: rtl/dnsx_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle and delivers one unless stalled.
// Separates the parser from the result channel and reports room for a full push.
// Depends on dnsx_pkg.
`default_nettype none

module dnsx_result_fifo (
  input  wire                clk,
  input  wire                rst,
  input  dnsx_pkg::push_t    push,
  output logic               room,
  output logic               valid,
  input  wire                stall,
  output dnsx_pkg::result_t  data
);
  import dnsx_pkg::*;

  result_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [FIFO_CNT_W-1:0]   count, count_next;
  logic [FIFO_PTR_W-1:0]   wr_ptr_plus1;
  logic                    pop;

  assign valid        = (count != '0);
  assign room         = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign pop          = valid && !stall;
  assign data         = entries[rd_ptr];
  assign wr_ptr_plus1 = wr_ptr + FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_PTR_W'(push.count);
    rd_ptr_next = pop ? rd_ptr + FIFO_PTR_W'(1) : rd_ptr;
    count_next  = count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // The queue never holds more than its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Results arrive only while there is room for a full push.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push into a queue without room");

  // Pointer distance always agrees with the fill count.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[FIFO_PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: tb/dns_answer_address_extractor_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the DNS answer address extractor top level.
// Sends random DNS responses byte by byte and checks each result against a parser model.
// Depends on dnsx_pkg and dns_answer_address_extractor_top.

module dns_answer_address_extractor_top_tb;
  import dnsx_pkg::*;

  class address_scoreboard;
    phase_t      phase;
    logic [3:0]  field_index;
    logic [17:0] records_left;
    logic [15:0] skip_left;
    logic [15:0] record_type;
    logic [15:0] rdata_len;
    logic [3:0]  rcode;
    logic [17:0] found;
    result_t     awaited[$];
    int          mismatches;

    function new();
      clear_parser();
      mismatches = 0;
    endfunction

    function void clear_parser();
      phase = PH_HEADER;
      field_index = '0;
      records_left = '0;
      skip_left = '0;
      record_type = '0;
      rdata_len = '0;
      rcode = '0;
      found = '0;
    endfunction

    // Walks one name byte; returns 1 when a zero label ends the name.
    function bit name_ended(logic [7:0] b, phase_t ptr_phase);
      if (skip_left != 0) begin
        skip_left--;
        return 1'b0;
      end
      if (b == 8'd0) return 1'b1;
      if (b >= PTR_MARK) phase = ptr_phase;
      else skip_left = 16'(b);
      return 1'b0;
    endfunction

    function bit carries_address();
      return record_type == TYPE_A || record_type == TYPE_AAAA;
    endfunction

    function void finish_record();
      records_left = records_left - 18'd1;
      phase = (records_left == 0) ? PH_DONE : PH_RNAME;
      skip_left = '0;
    endfunction

    function result_t make_result(kind_t kind, logic [7:0] abyte, logic v6, logic aend);
      result_t r;
      r.result_kind = kind;
      r.address_byte = abyte;
      r.is_ipv6 = v6;
      r.address_end = aend;
      r.response_code = (kind == KIND_ADDRESS) ? 4'd0 : rcode;
      r.address_count = (kind == KIND_ADDRESS) ? 18'd0 : found;
      r.run_end = 1'b0;
      return r;
    endfunction

    function void note_byte(packet_in_t item);
      logic [7:0] b;
      kind_t      kind;
      result_t    batch[$];
      b = item.packet_byte;
      case (phase)
        PH_HEADER: begin
          if (field_index == RCODE_INDEX) rcode = b[3:0];
          if (field_index >= COUNT_FIRST) begin
            if (!field_index[0]) skip_left = 16'(b);
            else records_left = records_left + 18'({skip_left[7:0], b});
          end
          if (field_index == RCODE_INDEX && rcode != 0) begin
            phase = PH_REJECT;
          end else if (field_index >= HEADER_LAST) begin
            phase = PH_QNAME;
            field_index = '0;
            skip_left = '0;
          end else begin
            field_index++;
          end
        end
        PH_QNAME: begin
          if (name_ended(b, PH_QPTR)) begin
            phase = PH_QFIXED;
            field_index = '0;
          end
        end
        PH_QPTR: begin
          phase = PH_QFIXED;
          field_index = '0;
        end
        PH_QFIXED: begin
          if (field_index >= QFIXED_LAST) begin
            phase = (records_left == 0) ? PH_DONE : PH_RNAME;
            field_index = '0;
            skip_left = '0;
          end else begin
            field_index++;
          end
        end
        PH_RNAME: begin
          if (name_ended(b, PH_RPTR)) begin
            phase = PH_RFIXED;
            field_index = '0;
          end
        end
        PH_RPTR: begin
          phase = PH_RFIXED;
          field_index = '0;
        end
        PH_RFIXED: begin
          case (field_index)
            RTYPE_HI: record_type = {b, 8'h00};
            RTYPE_LO: record_type[7:0] = b;
            RDLEN_HI: rdata_len = {b, 8'h00};
            RDLEN_LO: rdata_len[7:0] = b;
            default: ;
          endcase
          if (field_index >= RDLEN_LO) begin
            field_index = '0;
            if (carries_address()) found++;
            if (rdata_len == 0) begin
              finish_record();
            end else begin
              skip_left = rdata_len;
              phase = PH_RDATA;
            end
          end else begin
            field_index++;
          end
        end
        PH_RDATA: begin
          skip_left--;
          if (carries_address())
            batch.push_back(make_result(KIND_ADDRESS, b, record_type == TYPE_AAAA,
                                        skip_left == 0));
          if (skip_left == 0) finish_record();
        end
        default: ;
      endcase
      if (item.end_of_packet) begin
        if (phase == PH_REJECT) kind = KIND_REJECTED;
        else if (phase == PH_DONE) kind = KIND_OK;
        else kind = KIND_TRUNCATED;
        batch.push_back(make_result(kind, 8'd0, 1'b0, 1'b0));
        clear_parser();
      end
      if (batch.size() != 0) batch[batch.size() - 1].run_end = 1'b1;
      foreach (batch[i]) awaited.push_back(batch[i]);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result_kind of a result with none expected", got.result_kind, 32'd0);
        return;
      end
      want = awaited.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", got.result_kind, want.result_kind);
      if (got.address_byte !== want.address_byte)
        report_mismatch("address_byte", got.address_byte, want.address_byte);
      if (got.is_ipv6 !== want.is_ipv6)
        report_mismatch("is_ipv6", got.is_ipv6, want.is_ipv6);
      if (got.address_end !== want.address_end)
        report_mismatch("address_end", got.address_end, want.address_end);
      if (got.response_code !== want.response_code)
        report_mismatch("response_code", got.response_code, want.response_code);
      if (got.address_count !== want.address_count)
        report_mismatch("address_count", got.address_count, want.address_count);
      if (got.run_end !== want.run_end)
        report_mismatch("run_end", got.run_end, want.run_end);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  packet_in_t byte_item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result_item;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_pending = 1'b0;
  int         bytes_sent = 0;
  logic [7:0] msg_bytes[$];
  address_scoreboard results_board = new();

  dns_answer_address_extractor_top DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) results_board.check_result(result_item);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        repeat (400) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void add_random(int count);
    repeat (count) msg_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_word(logic [15:0] w);
    msg_bytes.push_back(w[15:8]);
    msg_bytes.push_back(w[7:0]);
  endfunction

  function automatic void add_name();
    int labels;
    int len;
    labels = $urandom_range(2);
    repeat (labels) begin
      len = ($urandom_range(99) < 3) ? $urandom_range(64, 191) : $urandom_range(1, 6);
      msg_bytes.push_back(8'(len));
      add_random(len);
    end
    if ($urandom_range(1)) begin
      msg_bytes.push_back(8'($urandom_range(192, 255)));
      add_random(1);
    end else begin
      msg_bytes.push_back(8'h00);
    end
  endfunction

  function automatic void add_record();
    int          pick;
    logic [15:0] rtype;
    logic [15:0] rdlen;
    pick = $urandom_range(9);
    add_name();
    if (pick < 4) rtype = TYPE_A;
    else if (pick < 7) rtype = TYPE_AAAA;
    else rtype = 16'($urandom_range(65535));
    add_word(rtype);
    add_random(6);
    if ($urandom_range(9) == 0) rdlen = 16'($urandom_range(20));
    else if (rtype == TYPE_A) rdlen = 16'd4;
    else if (rtype == TYPE_AAAA) rdlen = 16'd16;
    else if ($urandom_range(19) == 0) rdlen = 16'($urandom_range(256, 300));
    else rdlen = 16'($urandom_range(40));
    add_word(rdlen);
    add_random(rdlen);
  endfunction

  function automatic void build_response();
    int records;
    int count;
    msg_bytes.delete();
    add_random(3);
    msg_bytes.push_back({4'($urandom_range(15)), 4'h0});
    add_random(2);
    records = 0;
    repeat (3) begin
      count = $urandom_range(2);
      add_word(16'(count));
      records += count;
    end
    add_name();
    add_random(4);
    repeat (records) add_record();
    if ($urandom_range(3) == 0) add_random($urandom_range(1, 5));
  endfunction

  task automatic send_byte(logic [7:0] value, logic last);
    packet_in_t item;
    item.packet_byte = value;
    item.end_of_packet = last;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= item;
    @(posedge clk);
    while (byte_stall !== 1'b0) @(posedge clk);
    results_board.note_byte(item);
    bytes_sent++;
  endtask

  task automatic send_message(int length);
    for (int i = 0; i < length; i++) send_byte(msg_bytes[i], i == length - 1);
  endtask

  task automatic send_random_packet();
    int pick;
    int length;
    pick = $urandom_range(99);
    build_response();
    length = msg_bytes.size();
    if (pick >= 95) begin
      msg_bytes.delete();
      add_random($urandom_range(1, 40));
      length = msg_bytes.size();
    end else if (pick >= 85) begin
      msg_bytes[3] = {msg_bytes[3][7:4], 4'($urandom_range(1, 15))};
      length = $urandom_range(4, msg_bytes.size());
    end else if (pick >= 70) begin
      length = $urandom_range(1, msg_bytes.size() - 1);
    end
    send_message(length);
  endtask

  task automatic await_drain();
    int waited;
    waited = 0;
    byte_valid <= 1'b0;
    @(posedge clk);
    while (results_board.awaited.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A message that ends on its first byte is truncated.
    msg_bytes = '{8'hFF};
    send_message(1);
    // A nonzero rcode rejects the message; later bytes are ignored.
    msg_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_message(5);
    // No records: complete right after a root question name and its type and class.
    msg_bytes = '{8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
    send_message(17);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      await_drain();
      if (p == 0) hold_pending = 1'b1;
      while (bytes_sent < 23 + 460 * (p + 1)) send_random_packet();
    end

    await_drain();
    repeat (20) @(posedge clk);
    if (results_board.awaited.size() != 0)
      results_board.report_mismatch("results never delivered", results_board.awaited.size(), 0);
    if (results_board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
